>>> design/uer_pkg.sv
// shared widths, constants and inter-stage types of the echo ranger
`timescale 1ns / 1ps

package uer_pkg;

    localparam int unsigned TickW = 16;
    localparam int unsigned CmW   = 11;
    localparam int unsigned SumW  = 14;
    localparam int unsigned IdxW  = 3;

    localparam logic [CmW-1:0] CmMax = 11'd2047;

    typedef enum logic [1:0] {
        MODE_MIN  = 2'd0,
        MODE_MEAN = 2'd1,
        MODE_MAX  = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef struct packed {
        logic [TickW-1:0] trigger_ticks;
        logic [TickW-1:0] settle_ticks;
        logic [TickW-1:0] rise_timeout_ticks;
        logic [TickW-1:0] fall_timeout_ticks;
        logic [TickW-1:0] gap_ticks;
        logic [TickW-1:0] scale_q16;
    } t_cfg;

    // sequencer to scaler
    typedef struct packed {
        logic             trig;
        logic             busy;
        logic             fin;
        logic             take;
        logic             clear;
        t_mode            mode;
        logic [TickW-1:0] width;
    } t_evt;

    // scaler to accumulator
    typedef struct packed {
        logic           trig;
        logic           busy;
        logic           fin;
        logic           take;
        logic           clear;
        t_mode          mode;
        logic [CmW-1:0] cm;
    } t_scl;

    // accumulator to result select
    typedef struct packed {
        logic            trig;
        logic            busy;
        logic            fin;
        logic            mean;
        logic [SumW-1:0] val;
    } t_acc;

endpackage

>>> design/uer_seq.sv
// measurement sequencer: phase, tick counter and sample index, one tick per item
`timescale 1ns / 1ps

module uer_seq #(
    parameter int unsigned SAMPLES = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  uer_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  logic          i_start_req,
    input  logic [1:0]    i_mode,
    input  logic          i_echo,
    input  logic          i_next_ready,
    output logic          o_ready,
    output logic          o_valid,
    output uer_pkg::t_evt o_evt
);

    localparam int unsigned IdxCntW = uer_pkg::IdxW + 1;
    localparam int unsigned TickCntW = uer_pkg::TickW + 1;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_TRIG   = 6'b000010,
        PH_SETTLE = 6'b000100,
        PH_RISE   = 6'b001000,
        PH_MEAS   = 6'b010000,
        PH_GAP    = 6'b100000
    } t_phase;

    t_phase                      r_phase, n_phase;
    logic [uer_pkg::TickW-1:0]   r_tick, n_tick;
    logic [uer_pkg::IdxW-1:0]    r_idx, n_idx;
    uer_pkg::t_mode              r_mode, n_mode;
    logic                        r_valid;
    uer_pkg::t_evt               r_evt, n_evt;

    logic [TickCntW-1:0]         tick_inc;
    logic [IdxCntW-1:0]          idx_inc;
    logic                        adv_req, take_req, fire;
    logic [uer_pkg::TickW-1:0]   width;

    assign o_ready  = !r_valid || i_next_ready;
    assign fire     = i_valid && o_ready;
    assign tick_inc = {1'b0, r_tick} + TickCntW'(1);
    assign idx_inc  = {1'b0, r_idx} + IdxCntW'(1);

    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_idx    = r_idx;
        n_mode   = r_mode;
        adv_req  = 1'b0;
        take_req = 1'b0;
        width    = r_tick;
        n_evt    = '0;

        case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    n_mode      = uer_pkg::t_mode'(i_mode);
                    n_idx       = '0;
                    n_evt.clear = 1'b1;
                    n_phase     = PH_TRIG;
                    n_tick      = '0;
                end
            end
            PH_TRIG: begin
                n_evt.trig = 1'b1;
                n_tick     = tick_inc[uer_pkg::TickW-1:0];
                if (tick_inc >= {1'b0, i_cfg.trigger_ticks}) begin
                    n_tick  = '0;
                    n_phase = (i_cfg.settle_ticks == '0) ? PH_RISE : PH_SETTLE;
                end
            end
            PH_SETTLE: begin
                n_tick = tick_inc[uer_pkg::TickW-1:0];
                if (tick_inc >= {1'b0, i_cfg.settle_ticks}) begin
                    n_tick  = '0;
                    n_phase = PH_RISE;
                end
            end
            PH_RISE: begin
                if (i_echo) begin
                    n_tick  = '0;
                    n_phase = PH_MEAS;
                end else begin
                    n_tick = tick_inc[uer_pkg::TickW-1:0];
                    if (tick_inc >= {1'b0, i_cfg.rise_timeout_ticks}) begin
                        adv_req = 1'b1;
                    end
                end
            end
            PH_MEAS: begin
                if (!i_echo) begin
                    take_req = 1'b1;
                end else begin
                    n_tick = tick_inc[uer_pkg::TickW-1:0];
                    if (tick_inc >= {1'b0, i_cfg.fall_timeout_ticks}) begin
                        take_req = 1'b1;
                        width    = tick_inc[uer_pkg::TickW-1:0];
                    end
                end
            end
            PH_GAP: begin
                n_tick = tick_inc[uer_pkg::TickW-1:0];
                if (tick_inc >= {1'b0, i_cfg.gap_ticks}) begin
                    adv_req = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = '0;
            end
        endcase

        // zero width skips the sample, otherwise it is taken and a gap follows unless gap_ticks is zero
        if (take_req) begin
            if (width == '0) begin
                adv_req = 1'b1;
            end else begin
                n_evt.take = 1'b1;
                if (i_cfg.gap_ticks == '0) begin
                    adv_req = 1'b1;
                end else begin
                    n_phase = PH_GAP;
                    n_tick  = '0;
                end
            end
        end

        if (adv_req) begin
            if (idx_inc >= IdxCntW'(SAMPLES)) begin
                n_phase   = PH_IDLE;
                n_tick    = '0;
                n_evt.fin = 1'b1;
            end else begin
                n_idx   = idx_inc[uer_pkg::IdxW-1:0];
                n_phase = PH_TRIG;
                n_tick  = '0;
            end
        end

        n_evt.busy  = (n_phase != PH_IDLE);
        n_evt.mode  = n_mode;
        n_evt.width = width;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_idx   <= '0;
            r_mode  <= uer_pkg::MODE_MIN;
            r_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (fire) begin
                r_phase <= n_phase;
                r_tick  <= n_tick;
                r_idx   <= n_idx;
                r_mode  <= n_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_evt <= n_evt;
        end
    end

    assign o_valid = r_valid;
    assign o_evt   = r_evt;

`ifndef SYNTH
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_idx} < IdxCntW'(SAMPLES))
        else $error("sample index beyond sample count");

    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_evt.fin |-> !r_evt.busy)
        else $error("run end while still busy");

    a_clear_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_evt.clear |-> r_evt.busy && !r_evt.trig && !r_evt.fin)
        else $error("accumulator clear outside a run start");
`endif

endmodule

>>> design/uer_accum.sv
// width to centimetre scaling stage, then min, max and sum accumulation stage
`timescale 1ns / 1ps

module uer_accum (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  uer_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  uer_pkg::t_evt i_evt,
    input  logic          i_next_ready,
    output logic          o_ready,
    output logic          o_valid,
    output uer_pkg::t_acc o_acc
);

    localparam int unsigned ProdW = 2 * uer_pkg::TickW;

    logic                       r_v2, r_v3;
    uer_pkg::t_scl              r_scl, n_scl;
    uer_pkg::t_acc              r_acc, n_acc;
    logic [uer_pkg::CmW-1:0]    r_min, r_max, n_min, n_max;
    logic [uer_pkg::SumW-1:0]   r_sum, n_sum;

    logic [ProdW-1:0]           prod;
    logic [uer_pkg::TickW-1:0]  prod_hi;
    logic                       ready3, fire2, fire3;
    logic [uer_pkg::CmW-1:0]    mn0, mx0;
    logic                       reload;

    assign ready3  = !r_v3 || i_next_ready;
    assign o_ready = !r_v2 || ready3;
    assign fire2   = i_valid && o_ready;
    assign fire3   = r_v2 && ready3;

    // q0.16 scale, truncated, saturated
    assign prod    = i_evt.width * i_cfg.scale_q16;
    assign prod_hi = prod[ProdW-1:uer_pkg::TickW];

    always_comb begin
        n_scl.trig  = i_evt.trig;
        n_scl.busy  = i_evt.busy;
        n_scl.fin   = i_evt.fin;
        n_scl.take  = i_evt.take;
        n_scl.clear = i_evt.clear;
        n_scl.mode  = i_evt.mode;
        n_scl.cm    = (prod_hi > uer_pkg::TickW'(uer_pkg::CmMax)) ?
                      uer_pkg::CmMax : prod_hi[uer_pkg::CmW-1:0];
    end

    // an empty min or max reloads both from the sample
    assign reload = (r_min == '0) || (r_max == '0);
    assign mn0    = reload ? r_scl.cm : r_min;
    assign mx0    = reload ? r_scl.cm : r_max;

    always_comb begin
        n_min = r_min;
        n_max = r_max;
        n_sum = r_sum;
        if (r_scl.clear) begin
            n_min = '0;
            n_max = '0;
            n_sum = '0;
        end else if (r_scl.take) begin
            n_min = (r_scl.cm < mn0) ? r_scl.cm : mn0;
            n_max = (r_scl.cm > mx0) ? r_scl.cm : mx0;
            n_sum = r_sum + uer_pkg::SumW'(r_scl.cm);
        end

        n_acc.trig = r_scl.trig;
        n_acc.busy = r_scl.busy;
        n_acc.fin  = r_scl.fin;
        n_acc.mean = 1'b0;
        n_acc.val  = '0;
        if (r_scl.fin) begin
            case (r_scl.mode)
                uer_pkg::MODE_MIN:  n_acc.val = uer_pkg::SumW'(n_min);
                uer_pkg::MODE_MEAN: begin
                    n_acc.val  = n_sum;
                    n_acc.mean = 1'b1;
                end
                uer_pkg::MODE_MAX:  n_acc.val = uer_pkg::SumW'(n_max);
                default:            n_acc.val = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_min <= '0;
            r_max <= '0;
            r_sum <= '0;
        end else begin
            if (o_ready) begin
                r_v2 <= i_valid;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
            if (fire3) begin
                r_min <= n_min;
                r_max <= n_max;
                r_sum <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire2) begin
            r_scl <= n_scl;
        end
        if (fire3) begin
            r_acc <= n_acc;
        end
    end

    assign o_valid = r_v3;
    assign o_acc   = r_acc;

`ifndef SYNTH
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min <= r_max)
        else $error("minimum above maximum");
`endif

endmodule

>>> design/uer_select.sv
// mean by reciprocal multiply, saturation and the output register
`timescale 1ns / 1ps

module uer_select #(
    parameter int unsigned SAMPLES = 3
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  uer_pkg::t_acc            i_acc,
    input  logic                     i_m_tready,
    output logic                     o_ready,
    output logic                     o_valid,
    output logic                     o_trigger,
    output logic                     o_busy_res,
    output logic                     o_done_res,
    output logic [uer_pkg::CmW-1:0]  o_distance_cm
);

    localparam int unsigned DivShift = uer_pkg::SumW + $clog2(SAMPLES);
    localparam int unsigned RecipW   = DivShift + 1;
    localparam int unsigned QuoW     = uer_pkg::SumW + RecipW;
    localparam logic [RecipW-1:0] Recip = RecipW'((2 ** DivShift + SAMPLES - 1) / SAMPLES);

    logic                      r_vo, r_trig, r_busy, r_done;
    logic [uer_pkg::CmW-1:0]   r_dist, n_dist;
    logic [QuoW-1:0]           quo_full;
    logic [uer_pkg::SumW-1:0]  quo, sel;
    logic                      fire;

    assign o_ready  = !r_vo || i_m_tready;
    assign fire     = i_valid && o_ready;

    // exact floor division for any numerator of the sum width
    assign quo_full = i_acc.val * Recip;
    assign quo      = quo_full[DivShift +: uer_pkg::SumW];
    assign sel      = i_acc.mean ? quo : i_acc.val;
    assign n_dist   = (sel > uer_pkg::SumW'(uer_pkg::CmMax)) ?
                      uer_pkg::CmMax : sel[uer_pkg::CmW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (o_ready) begin
            r_vo <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_trig <= i_acc.trig;
            r_busy <= i_acc.busy;
            r_done <= i_acc.fin;
            r_dist <= n_dist;
        end
    end

    assign o_valid       = r_vo;
    assign o_trigger     = r_trig;
    assign o_busy_res    = r_busy;
    assign o_done_res    = r_done;
    assign o_distance_cm = r_dist;

`ifndef SYNTH
    a_dist_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo && !r_done |-> r_dist == '0)
        else $error("distance outside the done item");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo && r_done |-> !r_busy && !r_trig)
        else $error("done item still busy");
`endif

endmodule

>>> design/ultrasonic_echo_ranger_unit.sv
// top level of the ultrasonic echo ranger: ports, config registers, input register
`timescale 1ns / 1ps

// usage
//   every item on the slave stream is one microsecond tick: start request, mode
//   and sampled echo level; every accepted item yields exactly one item on the
//   master stream with the trigger level, busy flag, done flag (tlast) and distance
//   a start in idle runs SAMPLES trigger/echo measurements and reports min, mean or
//   max in centimetres on the done item, distance is zero on all other items
// timing
//   one item per cycle sustained while the master side accepts; the result of an item
//   passes through the five register stages on its way to the master side: input
//   register, sequencer, width scaling multiply, accumulator, mean divide/output
// reset
//   synchronous, active low; empties the pipeline, sequencer goes idle, the
//   accumulators clear and the timing registers return to their defaults
// stall
//   a stalled master side holds the output item; free stages keep accepting until
//   the pipeline is full, then s_tready drops; nothing is lost or repeated
// config
//   apb writes at byte address 4*index; the user must write only while the block is idle, the block does not enforce it

module ultrasonic_echo_ranger_unit #(
    parameter int unsigned SAMPLES = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] start_req, [2:1] mode, [3] echo, [7:4] zero

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [0] trigger, [1] busy_res, [12:2] distance_cm, [15:13] zero
    output logic        m_tlast,    // done_res

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        REG_TRIGGER = 3'd0,
        REG_SETTLE  = 3'd1,
        REG_RISE    = 3'd2,
        REG_FALL    = 3'd3,
        REG_GAP     = 3'd4,
        REG_SCALE   = 3'd5
    } t_reg_idx;

    uer_pkg::t_cfg              r_cfg;
    logic [15:0]                rd_val;
    logic                       cfg_wr;
    t_reg_idx                   reg_idx;

    // input register
    logic                       r_v0, r_start, r_echo;
    logic [1:0]                 r_mode;

    logic                       seq_ready, seq_valid;
    uer_pkg::t_evt              seq_evt;
    logic                       acc_ready, acc_valid;
    uer_pkg::t_acc              acc_res;
    logic                       sel_ready;
    logic                       out_trig, out_busy, out_done;
    logic [uer_pkg::CmW-1:0]    out_dist;

    // configuration port, write on the access cycle
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_ticks      <= 16'd10;
            r_cfg.settle_ticks       <= 16'd400;
            r_cfg.rise_timeout_ticks <= 16'd2000;
            r_cfg.fall_timeout_ticks <= 16'd20000;
            r_cfg.gap_ticks          <= 16'd50000;
            r_cfg.scale_q16          <= 16'd1124;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_TRIGGER: r_cfg.trigger_ticks      <= pwdata[15:0];
                REG_SETTLE:  r_cfg.settle_ticks       <= pwdata[15:0];
                REG_RISE:    r_cfg.rise_timeout_ticks <= pwdata[15:0];
                REG_FALL:    r_cfg.fall_timeout_ticks <= pwdata[15:0];
                REG_GAP:     r_cfg.gap_ticks          <= pwdata[15:0];
                REG_SCALE:   r_cfg.scale_q16          <= pwdata[15:0];
                default: ;  // unmapped addresses ignore writes
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TRIGGER: rd_val = r_cfg.trigger_ticks;
            REG_SETTLE:  rd_val = r_cfg.settle_ticks;
            REG_RISE:    rd_val = r_cfg.rise_timeout_ticks;
            REG_FALL:    rd_val = r_cfg.fall_timeout_ticks;
            REG_GAP:     rd_val = r_cfg.gap_ticks;
            REG_SCALE:   rd_val = r_cfg.scale_q16;
            default:     rd_val = '0;
        endcase
    end

    assign prdata = {16'd0, rd_val};

    // input register, refills whenever the sequencer takes its item
    assign s_tready = !r_v0 || seq_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (s_tready) begin
            r_v0 <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_start <= s_tdata[0];
            r_mode  <= s_tdata[2:1];
            r_echo  <= s_tdata[3];
        end
    end

    uer_seq #(
        .SAMPLES(SAMPLES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (r_v0),
        .i_start_req (r_start),
        .i_mode      (r_mode),
        .i_echo      (r_echo),
        .i_next_ready(acc_ready),
        .o_ready     (seq_ready),
        .o_valid     (seq_valid),
        .o_evt       (seq_evt)
    );

    uer_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (seq_valid),
        .i_evt       (seq_evt),
        .i_next_ready(sel_ready),
        .o_ready     (acc_ready),
        .o_valid     (acc_valid),
        .o_acc       (acc_res)
    );

    uer_select #(
        .SAMPLES(SAMPLES)
    ) u_select (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (acc_valid),
        .i_acc        (acc_res),
        .i_m_tready   (m_tready),
        .o_ready      (sel_ready),
        .o_valid      (m_tvalid),
        .o_trigger    (out_trig),
        .o_busy_res   (out_busy),
        .o_done_res   (out_done),
        .o_distance_cm(out_dist)
    );

    assign m_tdata = {3'd0, out_dist, out_busy, out_trig};
    assign m_tlast = out_done;

endmodule
